/* hw/rtl/kph_pkg.sv */
// Package for the kerning pair hash table: field widths, hash constants,
// parameter defaults and the request record passed from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kph_pkg;

  // Field widths
  localparam int CODE_W = 16;
  localparam int AMT_W  = 16;
  localparam int ENT_W  = 2 * CODE_W + AMT_W;

  // Home slot hash: left * MUL_L + right * MUL_R, below 2**HASH_W
  localparam int MUL_L  = 19;
  localparam int MUL_R  = 7;
  localparam int HASH_W = 21;

  // Parameter defaults
  localparam int TABLE_SIZE_DEF = 1024;
  localparam int MAX_PROBES_DEF = 32;

  // Action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // Request handed from the front to the back through the queue
  typedef struct packed {
    logic              action;
    logic              skip;     // reserved left code: no probing
    logic [CODE_W-1:0] left_code;
    logic [CODE_W-1:0] right_code;
    logic [AMT_W-1:0]  kern_amount;
  } req_t;

endpackage

`default_nettype wire

/* hw/rtl/kerning_pair_hash_table_core.sv */
// Kerning pair hash table. An item is reduced to its home slot in the front
// (directly for a power-of-two size, none for reserved left codes, else via
// multiply, subtract and fix states), queued, then probed slot by slot in the
// back, each slot read and then compared. The front takes a new item only once
// the last one is queued. Reset (rst_n, synchronous) empties the queue and
// clears the table with in_full high. Depends on kph_pkg, front, queue, back.
`timescale 1ns / 1ps
`default_nettype none

module kerning_pair_hash_table_core #(
  parameter int TABLE_SIZE = kph_pkg::TABLE_SIZE_DEF,
  parameter int MAX_PROBES = kph_pkg::MAX_PROBES_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_push,
  output logic                              in_full,
  input  wire                               in_action,
  input  wire  [kph_pkg::CODE_W-1:0]        in_left_code,
  input  wire  [kph_pkg::CODE_W-1:0]        in_right_code,
  input  wire  signed [kph_pkg::AMT_W-1:0]  in_kern_amount,
  input  wire                               out_pop,
  output logic                              out_empty,
  output logic signed [kph_pkg::AMT_W-1:0]  out_kern_value,
  output logic                              out_found,
  output logic                              out_overflow
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int QDW   = $bits(kph_pkg::req_t) + IDX_W;

  logic               clearing;
  logic               fq_push;
  logic               fq_full;
  kph_pkg::req_t      fq_req;
  logic [IDX_W-1:0]   fq_home;
  logic [QDW-1:0]     qb_data;
  logic               qb_empty;
  logic               qb_pop;
  kph_pkg::req_t      qb_req;
  logic [IDX_W-1:0]   qb_home;

  kph_front #(
    .TABLE_SIZE (TABLE_SIZE),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .clearing       (clearing),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_action      (in_action),
    .in_left_code   (in_left_code),
    .in_right_code  (in_right_code),
    .in_kern_amount (in_kern_amount),
    .q_push         (fq_push),
    .q_full         (fq_full),
    .q_req          (fq_req),
    .q_home         (fq_home)
  );

  kph_queue #(
    .DW (QDW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata ({fq_req, fq_home}),
    .full  (fq_full),
    .pop   (qb_pop),
    .rdata (qb_data),
    .empty (qb_empty)
  );

  // Split queue word into request and home slot
  assign qb_req  = qb_data[QDW-1 -: $bits(kph_pkg::req_t)];
  assign qb_home = qb_data[IDX_W-1:0];

  kph_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .MAX_PROBES (MAX_PROBES),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .clearing       (clearing),
    .q_req          (qb_req),
    .q_home         (qb_home),
    .q_empty        (qb_empty),
    .q_pop          (qb_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_kern_value (out_kern_value),
    .out_found      (out_found),
    .out_overflow   (out_overflow)
  );

endmodule

`default_nettype wire

/* hw/rtl/kph_front.sv */
// Front end: accepts items, flags the reserved left code and reduces the
// home hash modulo the table size. Depends on kph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kph_front #(
  parameter int TABLE_SIZE = kph_pkg::TABLE_SIZE_DEF,
  parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          clearing,
  input  wire                          in_push,
  output logic                         in_full,
  input  wire                          in_action,
  input  wire  [kph_pkg::CODE_W-1:0]   in_left_code,
  input  wire  [kph_pkg::CODE_W-1:0]   in_right_code,
  input  wire  [kph_pkg::AMT_W-1:0]    in_kern_amount,
  output logic                         q_push,
  input  wire                          q_full,
  output kph_pkg::req_t                q_req,
  output logic [IDX_W-1:0]             q_home
);

  localparam int QUO_W  = kph_pkg::HASH_W - IDX_W + 1;
  localparam int RCP_W  = kph_pkg::HASH_W + 1;
  localparam int PROD_W = kph_pkg::HASH_W + RCP_W;
  localparam int SHIFT  = kph_pkg::HASH_W + IDX_W;
  localparam bit POW2   = (TABLE_SIZE == (1 << IDX_W));
  // Scaled reciprocal of the table size, rounded down; the quotient estimate
  // falls short by at most one, so one compare and subtract finishes it
  localparam longint unsigned RECIP = (64'd1 << SHIFT) / 64'(TABLE_SIZE);
  localparam logic [RCP_W-1:0]           RCP    = RCP_W'(RECIP);
  localparam logic [IDX_W:0]             SIZE_X = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [kph_pkg::HASH_W-1:0] SIZE_H = kph_pkg::HASH_W'(TABLE_SIZE);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_SUB, F_FIX, F_HOLD} fstate_t;

  fstate_t             state_r;
  kph_pkg::req_t       req_r;
  logic [kph_pkg::HASH_W-1:0] hash_r;
  logic [QUO_W-1:0]    quo_r;
  logic [IDX_W:0]      rem_r;
  logic [kph_pkg::HASH_W-1:0] hash;
  logic                accept;
  logic [PROD_W-1:0]   prod;
  logic [kph_pkg::HASH_W-1:0] diff;

  // Home hash from the incoming codes
  assign hash = kph_pkg::HASH_W'(in_left_code) * kph_pkg::HASH_W'(kph_pkg::MUL_L)
              + kph_pkg::HASH_W'(in_right_code) * kph_pkg::HASH_W'(kph_pkg::MUL_R);

  assign in_full = (state_r != F_IDLE) || clearing;
  assign accept  = in_push && !in_full;

  // Quotient estimate and the remainder it leaves
  assign prod = PROD_W'(hash_r) * PROD_W'(RCP);
  assign diff = hash_r - kph_pkg::HASH_W'(quo_r) * SIZE_H;

  assign q_push = (state_r == F_HOLD);
  assign q_req  = req_r;
  assign q_home = rem_r[IDX_W-1:0];

  // Take an item, reduce it, hold until queued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            req_r.action      <= in_action;
            req_r.skip        <= (in_left_code == '0);
            req_r.left_code   <= in_left_code;
            req_r.right_code  <= in_right_code;
            req_r.kern_amount <= in_kern_amount;
            hash_r            <= hash;
            if (POW2) begin
              rem_r   <= (IDX_W + 1)'(hash[IDX_W-1:0]);
              state_r <= F_HOLD;
            end else begin
              state_r <= (in_left_code == '0) ? F_HOLD : F_MUL;
            end
          end
        end
        F_MUL: begin
          quo_r   <= prod[SHIFT +: QUO_W];
          state_r <= F_SUB;
        end
        F_SUB: begin
          rem_r   <= diff[IDX_W:0];
          state_r <= F_FIX;
        end
        F_FIX: begin
          rem_r   <= (rem_r >= SIZE_X) ? (rem_r - SIZE_X) : rem_r;
          state_r <= F_HOLD;
        end
        F_HOLD: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kph_queue.sv */
// Two-entry queue that decouples the front end from the probe engine.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps
`default_nettype none

module kph_queue #(
  parameter int DW = 8
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  wire  [DW-1:0] wdata,
  output logic          full,
  input  wire           pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Store on push
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kph_back.sv */
// Probe engine: holds the pair table, clears it after reset, walks a probe
// sequence whose steps are the squares 1, 4, 9, ... and fills the result register. Depends on kph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kph_back #(
  parameter int TABLE_SIZE = kph_pkg::TABLE_SIZE_DEF,
  parameter int MAX_PROBES = kph_pkg::MAX_PROBES_DEF,
  parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
  input  wire                               clk,
  input  wire                               rst_n,
  output logic                              clearing,
  input  kph_pkg::req_t                     q_req,
  input  wire  [IDX_W-1:0]                  q_home,
  input  wire                               q_empty,
  output logic                              q_pop,
  input  wire                               out_pop,
  output logic                              out_empty,
  output logic signed [kph_pkg::AMT_W-1:0]  out_kern_value,
  output logic                              out_found,
  output logic                              out_overflow
);

  localparam int CW = kph_pkg::CODE_W;
  localparam int AW = kph_pkg::AMT_W;
  localparam int KW = $clog2(MAX_PROBES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
  localparam logic [IDX_W:0]   SIZE_X   = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [KW-1:0]    K_LIMIT  = KW'(MAX_PROBES);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_RD, B_CMP} bstate_t;

  bstate_t                 state_r;
  logic [IDX_W-1:0]        clr_addr_r;
  kph_pkg::req_t           req_r;
  logic [IDX_W-1:0]        pos_r;
  logic [IDX_W-1:0]        d_r;
  logic [IDX_W-1:0]        o_r;
  logic [KW-1:0]           k_r;
  logic [kph_pkg::ENT_W-1:0] pair_table_r [TABLE_SIZE];
  logic [kph_pkg::ENT_W-1:0] rdata_r;
  logic                    out_valid_r;
  logic [AW-1:0]           out_value_r;
  logic                    out_found_r;
  logic                    out_over_r;

  logic [CW-1:0]           e_left;
  logic [CW-1:0]           e_right;
  logic [AW-1:0]           e_amt;
  logic                    e_empty;
  logic                    usable;
  logic                    at_limit;
  logic                    out_free;
  logic                    finish;
  logic                    out_load;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic [kph_pkg::ENT_W-1:0] wdata;

  // Add two residues and wrap once
  function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SIZE_X) begin
      s = s - SIZE_X;
    end
    return s[IDX_W-1:0];
  endfunction

  // Classify the slot just read
  assign e_left   = rdata_r[kph_pkg::ENT_W-1 -: CW];
  assign e_right  = rdata_r[AW +: CW];
  assign e_amt    = rdata_r[AW-1:0];
  assign e_empty  = (e_left == '0);
  assign usable   = e_empty || (e_left == req_r.left_code && e_right == req_r.right_code);
  assign at_limit = (k_r == K_LIMIT);
  assign out_free = !out_valid_r || out_pop;
  assign finish   = (state_r == B_CMP) && (usable || at_limit) && out_free;

  assign clearing = (state_r == B_CLEAR);
  assign q_pop    = (state_r == B_IDLE) && !q_empty && (!q_req.skip || out_free);
  assign out_load = finish || (q_pop && q_req.skip);

  // Table write: clearing pass, or insert at the usable slot
  assign we    = clearing ||
                 (finish && usable && req_r.action == kph_pkg::ACT_INSERT);
  assign waddr = clearing ? clr_addr_r : pos_r;
  assign wdata = clearing ? '0 : {req_r.left_code, req_r.right_code, req_r.kern_amount};

  always_ff @(posedge clk) begin
    if (we) begin
      pair_table_r[waddr] <= wdata;
    end
    rdata_r <= pair_table_r[pos_r];
  end

  assign out_empty      = !out_valid_r;
  assign out_kern_value = out_value_r;
  assign out_found      = out_found_r;
  assign out_overflow   = out_over_r;

  // Sequence clearing, probing and result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_IDX) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            req_r <= q_req;
            pos_r <= q_home;
            d_r   <= IDX_W'(1);
            o_r   <= IDX_W'(3);
            k_r   <= KW'(1);
            if (q_req.skip) begin
              out_value_r <= '0;
              out_found_r <= 1'b0;
              out_over_r  <= 1'b0;
            end else begin
              state_r <= B_RD;
            end
          end
        end
        B_RD: begin
          state_r <= B_CMP;
        end
        B_CMP: begin
          if (finish) begin
            out_found_r <= usable && !e_empty;
            out_over_r  <= !usable;
            out_value_r <= (usable && !e_empty && req_r.action == kph_pkg::ACT_LOOKUP)
                           ? e_amt : '0;
            state_r     <= B_IDLE;
          end else if (!usable && !at_limit) begin
            pos_r   <= add_mod(pos_r, d_r);
            d_r     <= add_mod(d_r, o_r);
            o_r     <= add_mod(o_r, IDX_W'(2));
            k_r     <= k_r + 1'b1;
            state_r <= B_RD;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kph_checker.sv */
// Port-level checks for kerning_pair_hash_table_core and the bind that
// attaches them. Depends on kph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kph_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_full,
  input wire                               out_pop,
  input wire                               out_empty,
  input wire signed [kph_pkg::AMT_W-1:0]   out_kern_value,
  input wire                               out_found,
  input wire                               out_overflow
);

  // Reset starts the clearing pass with no result waiting
  a_reset_blocks: assert property (@(posedge clk)
    !rst_n |=> in_full && out_empty)
    else $error("input not blocked or result present after reset");

  // Overflow result carries no hit and no amount
  a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_overflow |-> !out_found && out_kern_value == '0)
    else $error("overflow result with hit or amount");

  // A miss never reports an amount
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_found |-> out_kern_value == '0)
    else $error("miss result with nonzero amount");

  // Hold a result until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_kern_value) &&
      $stable(out_found) && $stable(out_overflow))
    else $error("result changed while stalled");

endmodule

bind kerning_pair_hash_table_core kph_checker u_kph_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_full        (in_full),
  .out_pop        (out_pop),
  .out_empty      (out_empty),
  .out_kern_value (out_kern_value),
  .out_found      (out_found),
  .out_overflow   (out_overflow)
);

`default_nettype wire
